@@ src/pbba_pkg.sv @@
// ----------------------------------------------------------------------------
// pbba_pkg
// Shared widths, command codes, controller/datapath interface types and
// saturating helpers for the path bounding box accumulator.
// ----------------------------------------------------------------------------
package pbba_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // curve numerator, denominator, divider remainder, ratio, product widths
    localparam int NW   = COORD_WIDTH + 1;
    localparam int DW   = COORD_WIDTH + 2;
    localparam int RW   = DW + 1;
    localparam int TW   = FRAC_BITS + 1;
    localparam int PW   = NW + TW;
    localparam int SW   = NW + 2;
    localparam int CNTW = $clog2(FRAC_BITS);

    localparam logic [TW-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [2:0] CMD_MOVE   = 3'd0;
    localparam logic [2:0] CMD_LINE   = 3'd1;
    localparam logic [2:0] CMD_CURVE  = 3'd2;
    localparam logic [2:0] CMD_RECT   = 3'd3;
    localparam logic [2:0] CMD_CIRCLE = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic setup;
        logic check;
        logic div_step;
        logic mul_a;
        logic mul_b;
        logic mul_bq;
        logic mul_q;
        logic eval;
        logic next_axis;
        logic curve_done;
        logic out_load;
    } pbba_cmd_t;

    typedef struct packed {
        logic is_curve;
        logic skip;
        logic t_one;
        logic div_done;
        logic axis_last;
        logic out_free;
    } pbba_sts_t;

    // clamp a value one bit wider than a coordinate
    function automatic coord_t sat_wide(input logic signed [COORD_WIDTH:0] s);
        coord_t r;
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
            r = s[COORD_WIDTH] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                               : {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end else begin
            r = s[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic coord_t sat_sum(input coord_t a, input coord_t b, input logic sub);
        logic signed [COORD_WIDTH:0] ea;
        logic signed [COORD_WIDTH:0] eb;
        logic signed [COORD_WIDTH:0] s;
        ea = $signed({a[COORD_WIDTH-1], a});
        eb = $signed({b[COORD_WIDTH-1], b});
        s  = sub ? (ea - eb) : (ea + eb);
        return sat_wide(s);
    endfunction

    function automatic coord_t min2(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t max2(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ src/pbba_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbba_ctrl
// Command sequencer: accepts a transfer, runs the simple update or the
// two-axis curve extent sequence, then hands the box to the output register.
// ----------------------------------------------------------------------------
module pbba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pbba_pkg::pbba_sts_t sts,
    output pbba_pkg::pbba_cmd_t cmd
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_EXEC   = 12'b0000_0000_0010,
        ST_SETUP  = 12'b0000_0000_0100,
        ST_CHECK  = 12'b0000_0000_1000,
        ST_DIV    = 12'b0000_0001_0000,
        ST_MUL_A  = 12'b0000_0010_0000,
        ST_MUL_B  = 12'b0000_0100_0000,
        ST_MUL_BQ = 12'b0000_1000_0000,
        ST_MUL_Q  = 12'b0001_0000_0000,
        ST_EVAL   = 12'b0010_0000_0000,
        ST_ACC    = 12'b0100_0000_0000,
        ST_RESP   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.is_curve ? ST_SETUP : ST_RESP;
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (sts.skip) begin
                    if (sts.axis_last) begin
                        state_next = ST_ACC;
                    end else begin
                        cmd.next_axis = 1'b1;
                        state_next    = ST_SETUP;
                    end
                end else begin
                    state_next = sts.t_one ? ST_MUL_A : ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.mul_b  = 1'b1;
                state_next = ST_MUL_BQ;
            end
            ST_MUL_BQ: begin
                cmd.mul_bq = 1'b1;
                state_next = ST_MUL_Q;
            end
            ST_MUL_Q: begin
                cmd.mul_q  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (sts.axis_last) begin
                    state_next = ST_ACC;
                end else begin
                    cmd.next_axis = 1'b1;
                    state_next    = ST_SETUP;
                end
            end
            ST_ACC: begin
                cmd.curve_done = 1'b1;
                state_next     = ST_RESP;
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_load_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_EXEC)
        else $error("accepted transfer did not start execution");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending transfer");

    a_div_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) && sts.div_done |=> state_reg == ST_MUL_A)
        else $error("divider finish not followed by evaluation");

endmodule

@@ src/pbba_dpath.sv @@
// ----------------------------------------------------------------------------
// pbba_dpath
// Datapath: pen and box state, saturating box sources, radix-2 restoring
// divider, shared magnitude multiplier and the output register.
// ----------------------------------------------------------------------------
module pbba_dpath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pbba_pkg::pbba_cmd_t    cmd,
    output pbba_pkg::pbba_sts_t    sts,
    input  logic [2:0]             s_command,
    input  pbba_pkg::coord_t       s_coord_ax,
    input  pbba_pkg::coord_t       s_coord_ay,
    input  pbba_pkg::coord_t       s_coord_bx,
    input  pbba_pkg::coord_t       s_coord_by,
    output logic                   m_valid,
    input  logic                   m_ready,
    output pbba_pkg::coord_t       m_box_min_x,
    output pbba_pkg::coord_t       m_box_min_y,
    output pbba_pkg::coord_t       m_box_max_x,
    output pbba_pkg::coord_t       m_box_max_y,
    output logic                   m_box_valid
);

    localparam int CW = pbba_pkg::COORD_WIDTH;
    localparam int NW = pbba_pkg::NW;
    localparam int DW = pbba_pkg::DW;
    localparam int RW = pbba_pkg::RW;
    localparam int TW = pbba_pkg::TW;
    localparam int PW = pbba_pkg::PW;
    localparam int SW = pbba_pkg::SW;
    localparam int FB = pbba_pkg::FRAC_BITS;

    logic [2:0]          cmd_reg;
    pbba_pkg::coord_t    ax_reg, ay_reg, bx_reg, by_reg;
    pbba_pkg::coord_t    pen_x_reg, pen_y_reg;
    pbba_pkg::coord_t    acc_min_x_reg, acc_min_y_reg, acc_max_x_reg, acc_max_y_reg;
    logic                empty_reg;
    logic                axis_reg;
    pbba_pkg::coord_t    p0_reg, p1_reg, p2_reg;
    pbba_pkg::coord_t    ext_min_reg [2];
    pbba_pkg::coord_t    ext_max_reg [2];
    logic                skip_reg;
    logic [RW-1:0]       r_reg;
    logic [DW-1:0]       ud_reg;
    logic [TW-1:0]       t_reg;
    logic [pbba_pkg::CNTW-1:0] cnt_reg;
    logic [PW-1:0]       prod_reg;
    logic                neg_reg;
    logic signed [NW-1:0] a_reg, b_reg;
    pbba_pkg::coord_t    out_min_x_reg, out_min_y_reg, out_max_x_reg, out_max_y_reg;
    logic                out_box_valid_reg;
    logic                m_valid_reg, m_valid_next;

    // curve setup for the current axis
    pbba_pkg::coord_t     sel_p0, sel_p1, sel_p2;
    logic signed [NW-1:0] n_val;
    logic signed [DW-1:0] d_val;
    logic [NW-1:0]        un_val;
    logic [DW-1:0]        ud_val;
    logic                 skip_val;

    assign sel_p0 = axis_reg ? pen_y_reg : pen_x_reg;
    assign sel_p1 = axis_reg ? ay_reg : ax_reg;
    assign sel_p2 = axis_reg ? by_reg : bx_reg;
    assign n_val  = $signed({sel_p0[CW-1], sel_p0}) - $signed({sel_p1[CW-1], sel_p1});
    assign d_val  = $signed({{2{sel_p0[CW-1]}}, sel_p0}) + $signed({{2{sel_p2[CW-1]}}, sel_p2})
                  - $signed({sel_p1[CW-1], sel_p1, 1'b0});
    assign un_val = n_val[NW-1] ? NW'(-n_val) : NW'(n_val);
    assign ud_val = d_val[DW-1] ? DW'(-d_val) : DW'(d_val);
    assign skip_val = (d_val == '0) || ((n_val != '0) && (n_val[NW-1] != d_val[DW-1]));

    // restoring divider step
    logic [RW-1:0] r_dbl, r_sub, ud_ext;
    logic          r_ge;

    assign ud_ext = {1'b0, ud_reg};
    assign r_dbl  = {r_reg[RW-2:0], 1'b0};
    assign r_ge   = r_dbl >= ud_ext;
    assign r_sub  = r_dbl - ud_ext;

    // shared multiplier: |v| * t, sign kept aside
    logic signed [NW-1:0] mul_v;
    logic [NW-1:0]        mul_abs;
    logic [PW-1:0]        mul_prod;

    always_comb begin
        case (1'b1)
            cmd.mul_b: mul_v = $signed({p2_reg[CW-1], p2_reg}) - $signed({p1_reg[CW-1], p1_reg});
            cmd.mul_q: mul_v = b_reg - a_reg;
            default:   mul_v = $signed({p1_reg[CW-1], p1_reg}) - $signed({p0_reg[CW-1], p0_reg});
        endcase
    end

    assign mul_abs  = mul_v[NW-1] ? NW'(-mul_v) : NW'(mul_v);
    assign mul_prod = PW'(mul_abs) * PW'(t_reg);

    // scaled term v*t/2^frac truncated toward zero
    logic [NW:0]          sc_mag;
    logic signed [SW-1:0] sc_val;
    logic signed [SW-1:0] a_sum, b_sum, q_sum;
    pbba_pkg::coord_t     q_sat;

    assign sc_mag = prod_reg[PW-1:FB];
    assign sc_val = neg_reg ? -$signed({1'b0, sc_mag}) : $signed({1'b0, sc_mag});
    assign a_sum  = $signed({{(SW-CW){p0_reg[CW-1]}}, p0_reg}) + sc_val;
    assign b_sum  = $signed({{(SW-CW){p1_reg[CW-1]}}, p1_reg}) + sc_val;
    assign q_sum  = $signed({{(SW-NW){a_reg[NW-1]}}, a_reg}) + sc_val;
    assign q_sat  = pbba_pkg::sat_wide(q_sum[NW-1:0]);

    // box sources
    pbba_pkg::coord_t rect_x1, rect_y1, circ_x0, circ_y0, circ_x1, circ_y1;
    pbba_pkg::coord_t bx0, by0, bx1, by1;
    pbba_pkg::coord_t nx, xx, ny, xy;
    logic             box_add;

    assign rect_x1 = pbba_pkg::sat_sum(ax_reg, bx_reg, 1'b0);
    assign rect_y1 = pbba_pkg::sat_sum(ay_reg, by_reg, 1'b0);
    assign circ_x0 = pbba_pkg::sat_sum(ax_reg, bx_reg, 1'b1);
    assign circ_y0 = pbba_pkg::sat_sum(ay_reg, bx_reg, 1'b1);
    assign circ_x1 = pbba_pkg::sat_sum(ax_reg, bx_reg, 1'b0);
    assign circ_y1 = pbba_pkg::sat_sum(ay_reg, bx_reg, 1'b0);

    always_comb begin
        case (cmd_reg)
            pbba_pkg::CMD_LINE: begin
                bx0 = pen_x_reg; by0 = pen_y_reg; bx1 = ax_reg; by1 = ay_reg;
            end
            pbba_pkg::CMD_RECT: begin
                bx0 = ax_reg; by0 = ay_reg; bx1 = rect_x1; by1 = rect_y1;
            end
            pbba_pkg::CMD_CIRCLE: begin
                bx0 = circ_x0; by0 = circ_y0; bx1 = circ_x1; by1 = circ_y1;
            end
            default: begin
                bx0 = ext_min_reg[0]; by0 = ext_min_reg[1];
                bx1 = ext_max_reg[0]; by1 = ext_max_reg[1];
            end
        endcase
    end

    assign nx = pbba_pkg::min2(bx0, bx1);
    assign xx = pbba_pkg::max2(bx0, bx1);
    assign ny = pbba_pkg::min2(by0, by1);
    assign xy = pbba_pkg::max2(by0, by1);
    assign box_add = (cmd.exec && ((cmd_reg == pbba_pkg::CMD_LINE) ||
                                   (cmd_reg == pbba_pkg::CMD_RECT) ||
                                   (cmd_reg == pbba_pkg::CMD_CIRCLE)))
                   || cmd.curve_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            acc_min_x_reg <= '0;
            acc_min_y_reg <= '0;
            acc_max_x_reg <= '0;
            acc_max_y_reg <= '0;
            empty_reg     <= 1'b1;
        end else begin
            if (box_add) begin
                empty_reg <= 1'b0;
                if (empty_reg) begin
                    acc_min_x_reg <= nx; acc_max_x_reg <= xx;
                    acc_min_y_reg <= ny; acc_max_y_reg <= xy;
                end else begin
                    acc_min_x_reg <= pbba_pkg::min2(acc_min_x_reg, nx);
                    acc_max_x_reg <= pbba_pkg::max2(acc_max_x_reg, xx);
                    acc_min_y_reg <= pbba_pkg::min2(acc_min_y_reg, ny);
                    acc_max_y_reg <= pbba_pkg::max2(acc_max_y_reg, xy);
                end
            end
            if (cmd.exec) begin
                case (cmd_reg)
                    pbba_pkg::CMD_MOVE, pbba_pkg::CMD_LINE, pbba_pkg::CMD_RECT: begin
                        pen_x_reg <= ax_reg;
                        pen_y_reg <= ay_reg;
                    end
                    pbba_pkg::CMD_CIRCLE: begin
                        pen_x_reg <= circ_x1;
                        pen_y_reg <= ay_reg;
                    end
                    pbba_pkg::CMD_CLEAR: begin
                        pen_x_reg     <= '0;
                        pen_y_reg     <= '0;
                        acc_min_x_reg <= '0;
                        acc_min_y_reg <= '0;
                        acc_max_x_reg <= '0;
                        acc_max_y_reg <= '0;
                        empty_reg     <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.curve_done) begin
                pen_x_reg <= bx_reg;
                pen_y_reg <= by_reg;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg  <= s_command;
            ax_reg   <= s_coord_ax;
            ay_reg   <= s_coord_ay;
            bx_reg   <= s_coord_bx;
            by_reg   <= s_coord_by;
            axis_reg <= 1'b0;
        end
        if (cmd.next_axis) begin
            axis_reg <= 1'b1;
        end
        if (cmd.setup) begin
            p0_reg   <= sel_p0;
            p1_reg   <= sel_p1;
            p2_reg   <= sel_p2;
            ext_min_reg[axis_reg] <= pbba_pkg::min2(sel_p0, sel_p2);
            ext_max_reg[axis_reg] <= pbba_pkg::max2(sel_p0, sel_p2);
            skip_reg <= skip_val;
            r_reg    <= RW'(un_val);
            ud_reg   <= ud_val;
        end
        if (cmd.check) begin
            t_reg   <= sts.t_one ? pbba_pkg::T_ONE : '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            r_reg   <= r_ge ? r_sub : r_dbl;
            t_reg   <= {t_reg[TW-2:0], r_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.mul_a || cmd.mul_b || cmd.mul_q) begin
            prod_reg <= mul_prod;
            neg_reg  <= mul_v[NW-1];
        end
        if (cmd.mul_b) begin
            a_reg <= a_sum[NW-1:0];
        end
        if (cmd.mul_bq) begin
            b_reg <= b_sum[NW-1:0];
        end
        if (cmd.eval) begin
            ext_min_reg[axis_reg] <= pbba_pkg::min2(ext_min_reg[axis_reg], q_sat);
            ext_max_reg[axis_reg] <= pbba_pkg::max2(ext_max_reg[axis_reg], q_sat);
        end
        if (cmd.out_load) begin
            out_min_x_reg     <= empty_reg ? '0 : acc_min_x_reg;
            out_min_y_reg     <= empty_reg ? '0 : acc_min_y_reg;
            out_max_x_reg     <= empty_reg ? '0 : acc_max_x_reg;
            out_max_y_reg     <= empty_reg ? '0 : acc_max_y_reg;
            out_box_valid_reg <= !empty_reg;
        end
    end

    assign m_valid_next = cmd.out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign sts.is_curve  = (cmd_reg == pbba_pkg::CMD_CURVE);
    assign sts.skip      = skip_reg || (r_reg > ud_ext);
    assign sts.t_one     = (r_reg == ud_ext);
    assign sts.div_done  = (cnt_reg == pbba_pkg::CNTW'(FB - 1));
    assign sts.axis_last = axis_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_box_min_x = out_min_x_reg;
    assign m_box_min_y = out_min_y_reg;
    assign m_box_max_x = out_max_x_reg;
    assign m_box_max_y = out_max_y_reg;
    assign m_box_valid = out_box_valid_reg;

    a_box_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty_reg |-> (acc_min_x_reg <= acc_max_x_reg) && (acc_min_y_reg <= acc_max_y_reg))
        else $error("accumulated box reversed");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_box_valid |-> (m_box_min_x == '0) && (m_box_max_x == '0) &&
                                    (m_box_min_y == '0) && (m_box_max_y == '0))
        else $error("empty box with nonzero bounds");

    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eval |-> t_reg <= pbba_pkg::T_ONE)
        else $error("curve parameter above one");

endmodule

@@ src/path_bounding_box_accumulator.sv @@
// ----------------------------------------------------------------------------
// path_bounding_box_accumulator
// Path command stream in, accumulated Q16.16 bounding box out.
// ----------------------------------------------------------------------------
// input channel s_*: one path command per transfer (move, line, quad curve,
// rectangle, circle, clear); codes six and seven leave the state alone.
// result channel m_*: exactly one box per command, in command order; the
// bounds read zero while m_box_valid is low.
// one command is worked on at a time. move, line, rectangle, circle and
// clear are done in the execute step before the hand-over; a quad curve
// runs two passes (one per axis) of setup, check, a 16-step radix-2
// restoring divider and five evaluation steps around the one shared
// multiplier. an axis whose extreme lies off the curve skips the divider
// and multiplier, and an axis whose ratio is exactly one skips the
// divider.
// s_ready is high whenever the sequencer is idle, even while a result is
// still held in the output register, so the next command overlaps the wait.
// if the receiver stalls the result stays in the output register and the
// next command waits for it only at its final hand-over step.
// reset (aresetn low, synchronous) empties the box, zeroes the pen and
// drops m_valid.
// ----------------------------------------------------------------------------
module path_bounding_box_accumulator (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_command,
    input  pbba_pkg::coord_t s_coord_ax,
    input  pbba_pkg::coord_t s_coord_ay,
    input  pbba_pkg::coord_t s_coord_bx,
    input  pbba_pkg::coord_t s_coord_by,
    output logic             m_valid,
    input  logic             m_ready,
    output pbba_pkg::coord_t m_box_min_x,
    output pbba_pkg::coord_t m_box_min_y,
    output pbba_pkg::coord_t m_box_max_x,
    output pbba_pkg::coord_t m_box_max_y,
    output logic             m_box_valid
);

    pbba_pkg::pbba_cmd_t cmd;
    pbba_pkg::pbba_sts_t sts;

    pbba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pbba_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_command   (s_command),
        .s_coord_ax  (s_coord_ax),
        .s_coord_ay  (s_coord_ay),
        .s_coord_bx  (s_coord_bx),
        .s_coord_by  (s_coord_by),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_box_min_x (m_box_min_x),
        .m_box_min_y (m_box_min_y),
        .m_box_max_x (m_box_max_x),
        .m_box_max_y (m_box_max_y),
        .m_box_valid (m_box_valid)
    );

endmodule

@@ tb/sv/tb_path_bounding_box_accumulator.sv @@
// ----------------------------------------------------------------------------
// tb_path_bounding_box_accumulator
// Drives path commands (move, line, quad curve, rectangle, circle, clear and
// the unused codes) into the bounding box accumulator and checks every
// returned box against a bit-accurate predictor held in the testbench.
// ----------------------------------------------------------------------------
module tb_path_bounding_box_accumulator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;
    localparam longint ONE_T = 64'sd65536;
    localparam int LIMIT_CYCLES = 900000;

    typedef struct {
        pbba_pkg::coord_t min_x;
        pbba_pkg::coord_t min_y;
        pbba_pkg::coord_t max_x;
        pbba_pkg::coord_t max_y;
        logic             valid;
    } box_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [2:0]       s_command = pbba_pkg::CMD_MOVE;
    pbba_pkg::coord_t s_coord_ax = '0;
    pbba_pkg::coord_t s_coord_ay = '0;
    pbba_pkg::coord_t s_coord_bx = '0;
    pbba_pkg::coord_t s_coord_by = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    pbba_pkg::coord_t m_box_min_x;
    pbba_pkg::coord_t m_box_min_y;
    pbba_pkg::coord_t m_box_max_x;
    pbba_pkg::coord_t m_box_max_y;
    logic             m_box_valid;

    // predictor state
    longint pen_x, pen_y, bmin_x, bmin_y, bmax_x, bmax_y;
    bit     empty;

    box_t   expected_boxes[$];
    int     mismatches = 0;
    int     boxes_seen = 0;
    int     cmds_sent = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;

    path_bounding_box_accumulator dut (.*);

    always #5 aclk = ~aclk;

    function automatic longint clamp(input longint v);
        return (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
    endfunction

    function automatic longint lmin(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    // v*t/2^16, truncated toward zero
    function automatic longint frac_scale(input longint v, input longint t);
        longint u, r;
        u = (v < 0) ? -v : v;
        r = (u >>> 16) * t + (((u & (ONE_T - 1)) * t) >>> 16);
        return (v < 0) ? -r : r;
    endfunction

    task automatic curve_extent(input longint p0, input longint p1, input longint p2,
                                output longint mn, output longint mx);
        longint n, d, un, ud, t, r, a, b, q;
        n = p0 - p1;
        d = p0 + p2 - 2 * p1;
        mn = lmin(p0, p2);
        mx = lmax(p0, p2);
        if (d == 0) return;
        if (n != 0 && ((n < 0) != (d < 0))) return;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        if (un > ud) return;
        if (un == ud) begin
            t = ONE_T;
        end else begin
            t = 0;
            r = un;
            for (int i = 0; i < 16; i++) begin
                r = r << 1;
                t = t << 1;
                if (r >= ud) begin
                    r = r - ud;
                    t = t | 1;
                end
            end
        end
        a = p0 + frac_scale(p1 - p0, t);
        b = p1 + frac_scale(p2 - p1, t);
        q = clamp(a + frac_scale(b - a, t));
        mn = lmin(mn, q);
        mx = lmax(mx, q);
    endtask

    task automatic grow_box(input longint x0, input longint y0, input longint x1,
                            input longint y1);
        if (empty) begin
            bmin_x = lmin(x0, x1); bmax_x = lmax(x0, x1);
            bmin_y = lmin(y0, y1); bmax_y = lmax(y0, y1);
            empty = 0;
        end else begin
            bmin_x = lmin(bmin_x, lmin(x0, x1)); bmax_x = lmax(bmax_x, lmax(x0, x1));
            bmin_y = lmin(bmin_y, lmin(y0, y1)); bmax_y = lmax(bmax_y, lmax(y0, y1));
        end
    endtask

    task automatic clear_state();
        pen_x = 0; pen_y = 0;
        bmin_x = 0; bmin_y = 0; bmax_x = 0; bmax_y = 0;
        empty = 1;
    endtask

    task automatic predict_box(input logic [2:0] cmd, input pbba_pkg::coord_t ax,
                               input pbba_pkg::coord_t ay, input pbba_pkg::coord_t bx,
                               input pbba_pkg::coord_t by);
        longint x0, y0, x1, y1, lx, ly, ux, uy;
        box_t   e;
        x0 = ax; y0 = ay; x1 = bx; y1 = by;
        case (cmd)
            pbba_pkg::CMD_MOVE: begin
                pen_x = x0; pen_y = y0;
            end
            pbba_pkg::CMD_LINE: begin
                grow_box(pen_x, pen_y, x0, y0);
                pen_x = x0; pen_y = y0;
            end
            pbba_pkg::CMD_CURVE: begin
                curve_extent(pen_x, x0, x1, lx, ux);
                curve_extent(pen_y, y0, y1, ly, uy);
                grow_box(lx, ly, ux, uy);
                pen_x = x1; pen_y = y1;
            end
            pbba_pkg::CMD_RECT: begin
                grow_box(x0, y0, clamp(x0 + x1), clamp(y0 + y1));
                pen_x = x0; pen_y = y0;
            end
            pbba_pkg::CMD_CIRCLE: begin
                grow_box(clamp(x0 - x1), clamp(y0 - x1), clamp(x0 + x1), clamp(y0 + x1));
                pen_x = clamp(x0 + x1); pen_y = y0;
            end
            pbba_pkg::CMD_CLEAR: clear_state();
            default: ;
        endcase
        e.min_x = pbba_pkg::coord_t'(bmin_x); e.min_y = pbba_pkg::coord_t'(bmin_y);
        e.max_x = pbba_pkg::coord_t'(bmax_x); e.max_y = pbba_pkg::coord_t'(bmax_y);
        e.valid = !empty;
        expected_boxes.insert(expected_boxes.size(), e);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch at result %0d: %s got %0d want %0d", boxes_seen, what, got, want);
    endtask

    // one command transfer; payload changes only at the falling edge
    task automatic send_cmd(input logic [2:0] cmd, input pbba_pkg::coord_t ax,
                            input pbba_pkg::coord_t ay, input pbba_pkg::coord_t bx,
                            input pbba_pkg::coord_t by);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_coord_ax <= ax; s_coord_ay <= ay; s_coord_bx <= bx; s_coord_by <= by;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_box(cmd, ax, ay, bx, by);
        cmds_sent++;
        @(negedge aclk);
    endtask

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        box_t e;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_path_bounding_box_accumulator: errors");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            boxes_seen++;
            if (expected_boxes.size() == 0) begin
                report_mismatch("unexpected box transfer", 1, 0);
            end else begin
                e = expected_boxes.pop_front();
                if (m_box_valid !== e.valid) report_mismatch("box_valid", m_box_valid, e.valid);
                if (m_box_min_x !== e.min_x) report_mismatch("min_x", m_box_min_x, e.min_x);
                if (m_box_min_y !== e.min_y) report_mismatch("min_y", m_box_min_y, e.min_y);
                if (m_box_max_x !== e.max_x) report_mismatch("max_x", m_box_max_x, e.max_x);
                if (m_box_max_y !== e.max_y) report_mismatch("max_y", m_box_max_y, e.max_y);
            end
        end
    end

    function automatic pbba_pkg::coord_t rand_coord();
        case ($urandom_range(5))
            0: return pbba_pkg::coord_t'($urandom);
            1: return pbba_pkg::coord_t'($signed($urandom_range(2000)) - 1000) <<< 16;
            2: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                        : 32'sh80000000 + $urandom_range(3);
            default: return pbba_pkg::coord_t'($signed($urandom_range(200000)) - 100000);
        endcase
    endfunction

    task automatic test_directed();
        pbba_pkg::coord_t big, tiny;
        big = 32'sh7fffffff;
        tiny = 32'sh80000000;
        send_cmd(pbba_pkg::CMD_LINE, 32'sh10000, 32'sh20000, 0, 0);
        send_cmd(pbba_pkg::CMD_MOVE, -32'sh30000, 32'sh5000, 0, 0);
        send_cmd(pbba_pkg::CMD_LINE, -32'sh50000, -32'sh1000, 0, 0);
        // curve with interior extremes on both axes
        send_cmd(pbba_pkg::CMD_CURVE, 32'sh40000, 32'sh90000, 32'sh10000, -32'sh20000);
        // curves with a degenerate (zero) denominator
        send_cmd(pbba_pkg::CMD_CURVE, 32'sh20000, 32'sh20000, 32'sh30000, 32'sh10000);
        send_cmd(pbba_pkg::CMD_CURVE, 32'sh30000, 32'sh10000, 32'sh30000, 32'sh10000);
        send_cmd(pbba_pkg::CMD_RECT, 32'sh1000, 32'sh1000, -32'sh5000, -32'sh6000);
        send_cmd(pbba_pkg::CMD_RECT, big, big, big, 32'sh100);
        send_cmd(pbba_pkg::CMD_CIRCLE, tiny, big, big, 0);
        send_cmd(pbba_pkg::CMD_CIRCLE, 0, 0, -32'sh10000, 0);
        send_cmd(pbba_pkg::CMD_CLEAR, big, tiny, big, tiny);
        send_cmd(3'd6, 32'sh1, 32'sh2, 32'sh3, 32'sh4);
        send_cmd(3'd7, big, big, big, big);
        send_cmd(pbba_pkg::CMD_MOVE, tiny, big, 0, 0);
        send_cmd(pbba_pkg::CMD_CURVE, big, tiny, tiny, big);
        send_cmd(pbba_pkg::CMD_CURVE, tiny, tiny, big, big);
        send_cmd(pbba_pkg::CMD_LINE, -1, -1, 0, 0);
        send_cmd(pbba_pkg::CMD_CLEAR, 0, 0, 0, 0);
    endtask

    task automatic test_random(input int count);
        logic [2:0] cmd;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 30) cmd = pbba_pkg::CMD_CURVE;
            else if (pick < 50) cmd = pbba_pkg::CMD_LINE;
            else if (pick < 62) cmd = pbba_pkg::CMD_MOVE;
            else if (pick < 75) cmd = pbba_pkg::CMD_RECT;
            else if (pick < 87) cmd = pbba_pkg::CMD_CIRCLE;
            else if (pick < 94) cmd = pbba_pkg::CMD_CLEAR;
            else cmd = 3'($urandom_range(7));
            send_cmd(cmd, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        clear_state();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 8; recv_idle_pct = 47;
        test_directed();
        test_random(440);
        send_idle_pct = 47; recv_idle_pct = 8;
        test_random(440);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(440);
        drain();
        $display("covered %0d commands and %0d checked boxes across three idle patterns",
                 cmds_sent, boxes_seen);
        if (mismatches == 0) begin
            $display("tb_path_bounding_box_accumulator: clean");
        end else begin
            $display("tb_path_bounding_box_accumulator: errors");
        end
        $finish;
    end

endmodule
